// ===== rtl/irtm_pkg.sv =====
// Shared constants, codes and types for the image rotate/translate mapper.
`default_nettype none

package irtm_pkg;

    // Default sizes
    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HEIGHT     = 1024;
    localparam int DEF_TRIG_FRAC_BITS = 14;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y      = 3'd4;

    // Field widths
    localparam int FRAME_W = 16;
    localparam int COORD_W = 10;
    localparam int PIX_W   = 8;
    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 11;
    localparam int SHIFT_W = 12;

    // Reset values of the registers
    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [FRAME_W-1:0] RST_NUM_FRAMES   = 16'd16;

    // Angle: floor(628 * frame * 2^28 / (100 * frames)) mod 2*pi, Q.28
    localparam int ANG_FRAC     = 28;
    localparam int ANG_W        = 32;
    localparam int ANG_MUL      = 628;
    localparam int ANG_DIV      = 100;
    localparam int NUM_W        = 26;   // 628 * frame
    localparam int DIV_W        = 23;   // 100 * frames
    localparam int QM_W         = 31;   // quotient kept modulo 2*pi
    localparam int DIV_STEPS    = NUM_W + ANG_FRAC;
    localparam int CORDIC_STEPS = 28;
    localparam int CNT_W        = $clog2(DIV_STEPS);
    localparam int CIDX_W       = $clog2(CORDIC_STEPS);
    localparam int ROT_TERMS    = 4;

    localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 32'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q      = 32'sd843314857;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 32'sd421657428;
    localparam logic signed [ANG_W-1:0] GAIN_Q    = 32'sd163008219;

    localparam logic [FRAME_W:0] NO_FRAME = '1;

    // atan(2^-i) in Q.28
    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32,
        32'sd16,        32'sd8,         32'sd4,        32'sd2
    };

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_FOLD,
        ST_CORDIC,
        ST_TRIG,
        ST_SRC,
        ST_MUL,
        ST_BOUND,
        ST_ADDR
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/image_rotate_translate_mapper.sv =====
// Top level: forward-mapping pixel rotator with translation and angle unit.
// Flow: an accepted word passes the source check, four passes of the shared
//   rotation multiplier, the bound check and the address step; a new frame
//   index first runs the 54-step divider, fold, 28-step CORDIC and store.
//   Rejected pixels give no result. One word is taken at a time, and the
//   address step waits while an earlier result is still unaccepted.
// Reset (synchronous, active low): registers to defaults, no frame cached.
`default_nettype none

module image_rotate_translate_mapper #(
    parameter int MAX_WIDTH      = irtm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = irtm_pkg::DEF_MAX_HEIGHT,
    parameter int TRIG_FRAC_BITS = irtm_pkg::DEF_TRIG_FRAC_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration
    input  wire                                i_cfg_we,
    input  wire [irtm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [irtm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input words
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [irtm_pkg::FRAME_W-1:0]        i_frame_index,
    input  wire [irtm_pkg::COORD_W-1:0]        i_pixel_row,
    input  wire [irtm_pkg::COORD_W-1:0]        i_pixel_col,
    input  wire [irtm_pkg::PIX_W-1:0]          i_pixel_value,
    // result words
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [irtm_pkg::ADDR_W-1:0]        o_write_address,
    output logic [irtm_pkg::PIX_W-1:0]         o_write_value
);
    import irtm_pkg::*;

    // Derived widths
    localparam int F        = TRIG_FRAC_BITS;
    localparam int TW       = F + 2;                       // Q2.F trig value
    localparam int DIM_BITS = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                              (($clog2(MAX_WIDTH) > COORD_W) ? $clog2(MAX_WIDTH) : COORD_W) :
                              (($clog2(MAX_HEIGHT) > COORD_W) ? $clog2(MAX_HEIGHT) : COORD_W);
    localparam int SZ_W     = DIM_BITS + 1;                // saturated size
    localparam int XW       = DIM_BITS + 3;                // signed coordinate
    localparam int BW       = (TW > XW) ? TW : XW;         // multiplier B side
    localparam int PRW      = XW + BW;                     // product
    localparam int ACC_W    = PRW + 1;                     // rotated coordinate
    localparam int RND_SH   = (ANG_FRAC > F) ? ANG_FRAC - F : 0;
    localparam int UP_SH    = (F > ANG_FRAC) ? F - ANG_FRAC : 0;
    localparam logic signed [ANG_W-1:0] TRIG_RND =
        (RND_SH > 0) ? (ANG_W'(1) << (RND_SH - 1)) : '0;
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << F) - 64'd1);

    // Configuration registers
    logic [SIZE_W-1:0]  r_image_width, r_image_height;
    logic [FRAME_W-1:0] r_num_frames;
    logic [SHIFT_W-1:0] r_shift_x, r_shift_y;

    // Angle state
    logic [FRAME_W:0]       r_cached;
    logic signed [TW-1:0]   r_sin, r_cos;

    // Sequencer and latched word
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [FRAME_W-1:0]     r_frame;
    logic [COORD_W-1:0]     r_row, r_col;
    logic [PIX_W-1:0]       r_val;

    // Divider / CORDIC working registers
    logic [NUM_W-1:0]       r_num;
    logic [DIV_W-1:0]       r_div, r_rem;
    logic [QM_W-1:0]        r_qm;
    logic signed [ANG_W-1:0] r_x, r_y, r_z;
    logic                   r_neg;

    // Pixel working registers
    logic signed [ACC_W-1:0] r_ro, r_co;
    logic signed [XW-1:0]   r_tr, r_tc;

    // Output register
    logic                   r_ov;
    logic [ADDR_W-1:0]      r_addr;
    logic [PIX_W-1:0]       r_wval;

    logic                   in_acc, out_free, hit;

    // ------------------------------------------------------------------
    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_num_frames   <= RST_NUM_FRAMES;
            r_shift_x      <= '0;
            r_shift_y      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[SIZE_W-1:0];
                CFG_NUM_FRAMES:   r_num_frames   <= i_cfg_data[FRAME_W-1:0];
                CFG_SHIFT_X:      r_shift_x      <= i_cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Y:      r_shift_y      <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Size and shift views
    logic [SZ_W-1:0]        w_eff, h_eff, hw, hh;
    logic [FRAME_W-1:0]     nf_eff;
    logic signed [XW-1:0]   sx, sy, hw_s, hh_s, row_c, col_c;

    always_comb begin
        w_eff  = (SZ_W'(r_image_width) > SZ_W'(MAX_WIDTH)) ? SZ_W'(MAX_WIDTH) :
                 SZ_W'(r_image_width);
        h_eff  = (SZ_W'(r_image_height) > SZ_W'(MAX_HEIGHT)) ? SZ_W'(MAX_HEIGHT) :
                 SZ_W'(r_image_height);
        hw     = w_eff >> 1;
        hh     = h_eff >> 1;
        nf_eff = (r_num_frames == '0) ? FRAME_W'(1) : r_num_frames;
        sx     = XW'($signed(r_shift_x));
        sy     = XW'($signed(r_shift_y));
        hw_s   = $signed(XW'(hw));
        hh_s   = $signed(XW'(hh));
        row_c  = $signed(XW'(r_row)) - hh_s;
        col_c  = $signed(XW'(r_col)) - hw_s;
    end

    // ------------------------------------------------------------------
    // Divider step: restoring, quotient kept modulo 2*pi
    logic [DIV_W:0]   rem_sh;
    logic             q_bit;
    logic [DIV_W:0]   rem_sub;
    logic [QM_W:0]    qm_sh;
    logic [QM_W-1:0]  qm_nx;
    logic [DIV_W-1:0] rem_nx;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        rem_nx  = q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        qm_sh   = {r_qm, q_bit};
        qm_nx   = (qm_sh >= $unsigned(TWO_PI_Q)) ?
                  QM_W'(qm_sh - $unsigned(TWO_PI_Q)) : qm_sh[QM_W-1:0];
    end

    // Fold the angle into [-pi/2, pi/2]
    logic signed [ANG_W-1:0] a_full, a_wrap, a_fold;
    logic                    a_neg;

    always_comb begin
        a_full = $signed({1'b0, r_qm});
        a_wrap = (a_full > PI_Q) ? a_full - TWO_PI_Q : a_full;
        a_fold = a_wrap;
        a_neg  = 1'b0;
        if (a_wrap > HALF_PI_Q) begin
            a_fold = a_wrap - PI_Q;
            a_neg  = 1'b1;
        end else if (a_wrap < -HALF_PI_Q) begin
            a_fold = a_wrap + PI_Q;
            a_neg  = 1'b1;
        end
    end

    // CORDIC micro-rotation
    logic [CIDX_W-1:0]       c_idx;
    logic signed [ANG_W-1:0] c_dx, c_dy, c_at;

    always_comb begin
        c_idx = r_cnt[CIDX_W-1:0];
        c_dx  = r_y >>> c_idx;
        c_dy  = r_x >>> c_idx;
        c_at  = ATAN_TAB[c_idx];
    end

    // Round the CORDIC result to Q2.F
    logic signed [ANG_W-1:0] x_fin, y_fin, x_rnd, y_rnd;

    always_comb begin
        x_fin = r_neg ? -r_x : r_x;
        y_fin = r_neg ? -r_y : r_y;
        x_rnd = ((x_fin + TRIG_RND) >>> RND_SH) <<< UP_SH;
        y_rnd = ((y_fin + TRIG_RND) >>> RND_SH) <<< UP_SH;
    end

    // ------------------------------------------------------------------
    // Shared multiplier: four rotation terms, then the row offset
    logic signed [XW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [PRW-1:0]   prod;
    logic signed [ACC_W-1:0] prod_x;

    always_comb begin
        mul_a = row_c;
        mul_b = BW'(r_cos);
        if (r_state == ST_ADDR) begin
            mul_a = r_tr;
            mul_b = $signed(BW'(w_eff));
        end else begin
            case (r_cnt[1:0])
                2'd0: begin mul_a = row_c; mul_b = BW'(r_cos); end
                2'd1: begin mul_a = col_c; mul_b = BW'(r_sin); end
                2'd2: begin mul_a = col_c; mul_b = BW'(r_cos); end
                default: begin mul_a = row_c; mul_b = BW'(r_sin); end
            endcase
        end
        prod   = mul_a * mul_b;
        prod_x = ACC_W'(prod);
    end

    // Checks and truncation toward zero
    logic                    src_ok, bnd_ok;
    logic signed [ACC_W-1:0] sx_q, sy_q, hw_q, hh_q, ro_t, co_t;
    logic signed [ACC_W-1:0] ro_tz, co_tz;
    logic [ADDR_W-1:0]       addr_nx;

    always_comb begin
        src_ok  = (SZ_W'(r_row) < {hh[SZ_W-2:0], 1'b0}) &&
                  (SZ_W'(r_col) < {hw[SZ_W-2:0], 1'b0});
        sx_q    = ACC_W'(sx) <<< F;
        sy_q    = ACC_W'(sy) <<< F;
        hw_q    = ACC_W'(hw_s) <<< F;
        hh_q    = ACC_W'(hh_s) <<< F;
        ro_t    = r_ro + sy_q;
        co_t    = r_co + sx_q;
        bnd_ok  = (ro_t < hh_q) && (ro_t >= -hh_q) && (co_t < hw_q) && (co_t >= -hw_q);
        ro_tz   = (r_ro + (r_ro[ACC_W-1] ? TRUNC_BIAS : '0)) >>> F;
        co_tz   = (r_co + (r_co[ACC_W-1] ? TRUNC_BIAS : '0)) >>> F;
        addr_nx = ADDR_W'(prod + PRW'(r_tc));
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;
    assign hit      = ({1'b0, i_frame_index} == r_cached);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = hit ? ST_SRC : ST_DIV;
            ST_DIV:    if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_FOLD;
            ST_FOLD:   n_state = ST_CORDIC;
            ST_CORDIC: if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = ST_TRIG;
            ST_TRIG:   n_state = ST_SRC;
            ST_SRC:    n_state = src_ok ? ST_MUL : ST_IDLE;
            ST_MUL:    if (r_cnt == CNT_W'(ROT_TERMS - 1)) n_state = ST_BOUND;
            ST_BOUND:  n_state = bnd_ok ? ST_ADDR : ST_IDLE;
            ST_ADDR:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_DIV, ST_CORDIC, ST_MUL: r_cnt <= r_cnt + CNT_W'(1);
                default:                   r_cnt <= '0;
            endcase
            if (r_state == ST_ADDR && out_free) r_ov <= 1'b1;
            else if (i_out_ready)               r_ov <= 1'b0;
        end
    end

    // Angle cache
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached <= NO_FRAME;
            r_sin    <= '0;
            r_cos    <= '0;
        end else if (i_cfg_we && i_cfg_index == CFG_NUM_FRAMES) begin
            r_cached <= NO_FRAME;
        end else if (r_state == ST_TRIG) begin
            r_cached <= {1'b0, r_frame};
            r_cos    <= x_rnd[TW-1:0];
            r_sin    <= y_rnd[TW-1:0];
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_frame <= i_frame_index;
                    r_row   <= i_pixel_row;
                    r_col   <= i_pixel_col;
                    r_val   <= i_pixel_value;
                    r_num   <= NUM_W'(ANG_MUL * i_frame_index);
                    r_div   <= DIV_W'(ANG_DIV * nf_eff);
                    r_rem   <= '0;
                    r_qm    <= '0;
                end
            end
            ST_DIV: begin
                r_num <= r_num << 1;
                r_rem <= rem_nx;
                r_qm  <= qm_nx;
            end
            ST_FOLD: begin
                r_x   <= GAIN_Q;
                r_y   <= '0;
                r_z   <= a_fold;
                r_neg <= a_neg;
            end
            ST_CORDIC: begin
                if (!r_z[ANG_W-1]) begin
                    r_x <= r_x - c_dx;
                    r_y <= r_y + c_dy;
                    r_z <= r_z - c_at;
                end else begin
                    r_x <= r_x + c_dx;
                    r_y <= r_y - c_dy;
                    r_z <= r_z + c_at;
                end
            end
            ST_MUL: begin
                case (r_cnt[1:0])
                    2'd0:    r_ro <= prod_x;
                    2'd1:    r_ro <= r_ro + prod_x;
                    2'd2:    r_co <= prod_x;
                    default: r_co <= r_co - prod_x;
                endcase
            end
            ST_BOUND: begin
                r_tr <= XW'(ro_tz + ACC_W'(sy) + ACC_W'(hh_s));
                r_tc <= XW'(co_tz + ACC_W'(sx) + ACC_W'(hw_s));
            end
            ST_ADDR: begin
                if (out_free) begin
                    r_addr <= addr_nx;
                    r_wval <= r_val;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_ov;
    assign o_write_address = r_addr;
    assign o_write_value   = r_wval;

endmodule

`default_nettype wire

// ===== rtl/irtm_checker.sv =====
// Port-level checker for the image rotate/translate mapper, bound to the top.
`default_nettype none

module irtm_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            o_in_ready,
    input  wire                            o_out_valid,
    input  wire                            i_out_ready,
    input  wire [irtm_pkg::ADDR_W-1:0]     o_write_address,
    input  wire [irtm_pkg::PIX_W-1:0]      o_write_value
);
    // A waiting result word holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_write_address) && $stable(o_write_value))
        else $error("result word changed while stalled");

    // One word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // No result can appear right after an accept
    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result too early");

    // A new result arrives exactly as the sequencer returns to idle
    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while busy");

    // Reset leaves the block idle and empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("bad state after reset");

endmodule

bind image_rotate_translate_mapper irtm_checker u_irtm_checker (.*);

`default_nettype wire
